>>> sv/pwrseq_pkg.sv
`timescale 1ns / 1ps
// Package for the power up/down sequencer: item types, phase and action codes,
// timing constants. Depends on nothing; every other file imports it.
package pwrseq_pkg;

  // Timing constants: tick and slice lengths in milliseconds, pauses in ticks, restart in slices.
  localparam int TICK_MS          = 10;
  localparam int RESTART_SLICE_MS = 10;

  localparam logic [15:0] PAUSE_MUTE  = 16'(200 / TICK_MS);
  localparam logic [15:0] PAUSE_POWER = 16'(1000 / TICK_MS);
  localparam logic [15:0] PAUSE_SHUT  = 16'(100 / TICK_MS);
  localparam logic [7:0]  RESTART_STEPS = 8'(1000 / RESTART_SLICE_MS);

  // Reciprocal used to turn a 16 bit millisecond value into ticks.
  localparam int DIV_L  = $clog2(TICK_MS);
  localparam int DIV_SH = 16 + DIV_L;
  localparam int DIV_W  = DIV_SH + 16;
  localparam logic [DIV_W-1:0] DIV_M = DIV_W'(((64'd1 << DIV_SH) + 64'(TICK_MS) - 64'd1)
                                              / 64'(TICK_MS));

  // Configuration register indexes.
  localparam logic [2:0] REG_HOT_RESTART   = 3'd0;
  localparam logic [2:0] REG_AUTO_RESTART  = 3'd1;
  localparam logic [2:0] REG_LATCHING_SW   = 3'd2;
  localparam logic [2:0] REG_BOOT_FINISH   = 3'd3;
  localparam logic [2:0] REG_UNMUTE_TMO    = 3'd4;

  localparam logic [15:0] BOOT_FINISH_RST = 16'd5000;
  localparam logic [15:0] UNMUTE_TMO_RST  = 16'd10000;
  localparam logic [15:0] BOOT_PAUSE_RST  = 16'(5000 / TICK_MS);

  // Phase codes.
  localparam logic [2:0] PH_NONE    = 3'd0;
  localparam logic [2:0] PH_WAITPG  = 3'd1;
  localparam logic [2:0] PH_STANDBY = 3'd2;
  localparam logic [2:0] PH_BOOT    = 3'd3;
  localparam logic [2:0] PH_RUN     = 3'd4;
  localparam logic [2:0] PH_SHUT    = 3'd5;
  localparam logic [2:0] PH_HOT     = 3'd6;

  // Reported run states.
  localparam logic [2:0] REP_STANDBY  = 3'd1;
  localparam logic [2:0] REP_BOOTING  = 3'd2;
  localparam logic [2:0] REP_RUNNING  = 3'd3;
  localparam logic [2:0] REP_SHUTDOWN = 3'd4;

  // LED patterns.
  localparam logic [2:0] LED_NONE      = 3'd0;
  localparam logic [2:0] LED_VERY_FAST = 3'd1;
  localparam logic [2:0] LED_SHOW_IDS  = 3'd2;
  localparam logic [2:0] LED_STANDBY   = 3'd3;
  localparam logic [2:0] LED_MEDIUM    = 3'd4;
  localparam logic [2:0] LED_ON        = 3'd5;
  localparam logic [2:0] LED_FAST      = 3'd6;

  // Active-state change codes.
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_SET   = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  // Action bit positions.
  localparam int A_MUTE     = 0;
  localparam int A_PCINIT   = 1;
  localparam int A_SYSON    = 2;
  localparam int A_BUS_EN   = 3;
  localparam int A_PCON     = 4;
  localparam int A_HOST_RST = 5;
  localparam int A_MONSTART = 6;
  localparam int A_MONSTOP  = 7;
  localparam int A_CLROVR   = 8;
  localparam int A_ALLOFF   = 9;
  localparam int A_SYSOFF   = 10;
  localparam int A_ARM      = 11;
  localparam int A_SERIN    = 12;
  localparam int A_SERDE    = 13;
  localparam int A_HB       = 14;
  localparam int A_GLITCH1  = 15;
  localparam int A_GLITCH2  = 16;

  localparam logic OP_START = 1'b0;

  typedef struct packed {
    logic operation;
    logic power_good;
    logic switch_on_event;
    logic switch_off_event;
    logic switch_released;
    logic system_locked;
    logic pc_is_off;
    logic board_is_off;
    logic pc_changed;
    logic board_changed;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  run_state;
    logic [2:0]  led_command;
    logic [16:0] actions;
    logic [15:0] monitor_timeout_ms;
    logic        running_flag;
    logic [1:0]  active_change;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic [7:0]  step_count;
    logic [15:0] pause_count;
    logic        restart_pending;
    logic [2:0]  reported_state;
  } seq_state_t;

  typedef struct packed {
    logic        hot_restart;
    logic        auto_restart;
    logic        latching_switch;
    logic [15:0] boot_finish_ms;
    logic [15:0] boot_pause;
    logic [15:0] unmute_timeout_ms;
  } cfg_t;

endpackage

>>> sv/pwrseq_step.sv
`timescale 1ns / 1ps
// Next-state and result logic for one item of the power sequencer.
// Purely combinational; depends on pwrseq_pkg.
module pwrseq_step (
  input  pwrseq_pkg::seq_state_t state_i,
  input  pwrseq_pkg::cfg_t       cfg_i,
  input  pwrseq_pkg::in_item_t   item_i,
  output pwrseq_pkg::seq_state_t state_o,
  output pwrseq_pkg::out_item_t  result_o
);
  import pwrseq_pkg::*;

  seq_state_t  st;
  logic [2:0]  led;
  logic [16:0] act;
  logic [15:0] mon;
  logic [1:0]  active;
  logic [2:0]  target;
  logic        go;
  logic        cleared;
  logic [7:0]  step_inc;
  logic [15:0] unmute_rest;

  assign step_inc    = state_i.step_count + 8'd1;
  assign unmute_rest = (cfg_i.unmute_timeout_ms > cfg_i.boot_finish_ms) ?
                       (cfg_i.unmute_timeout_ms - cfg_i.boot_finish_ms) : 16'd0;

  always_comb begin
    st      = state_i;
    led     = LED_NONE;
    act     = '0;
    mon     = '0;
    active  = ACT_NONE;
    go      = 1'b0;
    target  = PH_NONE;
    cleared = 1'b0;

    // First pass: decide the step and whether a phase change follows.
    if (item_i.operation == OP_START) begin
      st.restart_pending = cfg_i.auto_restart;
      go     = 1'b1;
      target = cfg_i.hot_restart ? PH_HOT : PH_WAITPG;
    end else if (state_i.pause_count != 16'd0) begin
      st.pause_count = state_i.pause_count - 16'd1;
    end else begin
      case (state_i.phase)
        PH_WAITPG: begin
          if (state_i.step_count == 8'd0) begin
            st.step_count = 8'd1;
            led = LED_VERY_FAST;
          end
          if (item_i.power_good) begin
            led    = LED_SHOW_IDS;
            go     = 1'b1;
            target = PH_STANDBY;
          end
        end
        PH_STANDBY: begin
          case (state_i.step_count)
            8'd0: begin
              led = LED_STANDBY;
              st.step_count = 8'd1;
            end
            8'd1: begin
              if (cfg_i.latching_switch || item_i.switch_released) begin
                act[A_ARM] = 1'b1;
                st.step_count = 8'd2;
              end
            end
            8'd2: begin
              if (item_i.switch_on_event || state_i.restart_pending) begin
                if (state_i.restart_pending) begin
                  st.step_count = 8'd3;
                end else begin
                  go     = 1'b1;
                  target = PH_BOOT;
                end
                st.restart_pending = 1'b0;
              end
            end
            default: begin
              st.step_count = step_inc;
              if (step_inc >= RESTART_STEPS) begin
                go     = 1'b1;
                target = PH_BOOT;
              end
            end
          endcase
        end
        PH_BOOT: begin
          case (state_i.step_count)
            8'd0: begin
              st.step_count  = 8'd1;
              led            = LED_MEDIUM;
              act[A_MUTE]    = 1'b1;
              st.pause_count = PAUSE_MUTE;
            end
            8'd1: begin
              st.step_count  = 8'd2;
              act[A_PCINIT]  = 1'b1;
              act[A_SYSON]   = 1'b1;
              act[A_BUS_EN]  = 1'b1;
              st.pause_count = PAUSE_POWER;
            end
            8'd2: begin
              st.step_count  = 8'd3;
              act[A_PCON]    = 1'b1;
              st.pause_count = PAUSE_POWER;
            end
            8'd3: begin
              st.step_count   = 8'd4;
              act[A_HOST_RST] = 1'b1;
              st.pause_count  = cfg_i.boot_pause;
            end
            8'd4: begin
              act[A_MONSTART] = 1'b1;
              act[A_ARM]      = 1'b1;
              mon    = unmute_rest;
              go     = 1'b1;
              target = PH_RUN;
            end
            default: begin
            end
          endcase
        end
        PH_RUN: begin
          if (item_i.switch_off_event && !item_i.system_locked) begin
            go     = 1'b1;
            target = PH_SHUT;
          end else if (state_i.step_count == 8'd0) begin
            st.step_count = 8'd1;
            led        = LED_ON;
            act[A_HB]  = 1'b1;
            cleared    = 1'b1;
          end else if (state_i.step_count == 8'd1) begin
            st.step_count = 8'd2;
          end
          if (!cleared) begin
            act[A_GLITCH1] = item_i.pc_changed;
            act[A_GLITCH2] = item_i.board_changed;
          end
        end
        PH_SHUT: begin
          if (state_i.step_count == 8'd0) begin
            act[A_MONSTOP] = 1'b1;
            act[A_CLROVR]  = 1'b1;
            act[A_MUTE]    = 1'b1;
            act[A_ALLOFF]  = 1'b1;
            st.step_count  = 8'd1;
            led            = LED_FAST;
            st.pause_count = PAUSE_SHUT;
          end else if (item_i.pc_is_off && item_i.board_is_off) begin
            act[A_SYSOFF] = 1'b1;
            go     = 1'b1;
            target = PH_STANDBY;
          end
        end
        PH_HOT: begin
          act[A_MONSTART] = 1'b1;
          act[A_ARM]      = 1'b1;
          go     = 1'b1;
          target = PH_RUN;
        end
        default: begin
        end
      endcase
    end

    // Second pass: apply the phase change and its side effects.
    if (go) begin
      st.phase       = target;
      st.step_count  = 8'd0;
      st.pause_count = 16'd0;
      case (target)
        PH_STANDBY: begin
          st.reported_state = REP_STANDBY;
          act[A_SERDE] = 1'b1;
          // Leaving shutdown waits out the power-off settle time.
          if (state_i.phase == PH_SHUT && item_i.operation != OP_START) begin
            st.pause_count = PAUSE_POWER;
          end
        end
        PH_BOOT: begin
          st.reported_state = REP_BOOTING;
          act[A_SERIN] = 1'b1;
          active = ACT_SET;
        end
        PH_HOT: begin
          st.reported_state = REP_BOOTING;
          act[A_SERIN] = 1'b1;
        end
        PH_RUN: begin
          st.reported_state = REP_RUNNING;
          active = ACT_SET;
        end
        PH_SHUT: begin
          st.reported_state = REP_SHUTDOWN;
          active = ACT_CLEAR;
        end
        default: begin
        end
      endcase
    end
  end

  assign state_o = st;

  assign result_o.run_state          = st.reported_state;
  assign result_o.led_command        = led;
  assign result_o.actions            = act;
  assign result_o.monitor_timeout_ms = mon;
  assign result_o.running_flag       = (st.phase == PH_RUN);
  assign result_o.active_change      = active;

endmodule

>>> sv/power_up_down_sequencer_top.sv
`timescale 1ns / 1ps
// Top level of the power up/down sequencer: input register, step logic and result register.
// Depends on pwrseq_pkg and pwrseq_step.
//
// Usage. Items enter on in_item_i under in_valid_i; an item is taken at a rising edge where
// in_valid_i is high and in_stall_o is low. An item with operation 0 starts the sequencer,
// an item with operation 1 is one time-slice tick. Every item gives exactly one result item
// on out_item_o under out_valid_o, taken when out_stall_i is low.
// The result item is held first in the input register; then the step logic writes the
// sequencer state and the result register together, once the result register is free.
// Throughput is one item per clock while the receiver does not stall; the only loop is the
// state register fed back through the combinational step logic.
// When the receiver stalls, the waiting result holds in the result register and the input
// register still takes one more item; only when both are full does in_stall_o rise.
// Configuration writes use cfg_valid_i, cfg_index_i and cfg_data_i and are always ready.
// They are meant for idle periods only. Writing boot_finish_ms also stores its tick count,
// worked out by a reciprocal multiplication on the way into the register.
// Reset (rst_ni low) empties both registers, clears the sequencer to "no phase" and loads
// the register defaults; the block accepts items as soon as reset is released.
module power_up_down_sequencer_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  pwrseq_pkg::in_item_t  in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output pwrseq_pkg::out_item_t out_item_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [2:0]            cfg_index_i,
  input  logic [15:0]           cfg_data_i
);
  import pwrseq_pkg::*;

  logic       in_vld_q;
  in_item_t   in_item_q;
  logic       out_vld_q;
  out_item_t  out_item_q;
  seq_state_t state_q, state_d;
  out_item_t  result_d;
  cfg_t       cfg_q;
  logic       out_free;
  logic       step_fire;
  logic       in_take;
  logic       cfg_we;
  logic [DIV_W-1:0] ticks_prod;

  // The result register can take a new item when empty or when its item leaves now.
  assign out_free  = !out_vld_q || !out_stall_i;
  assign step_fire = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_take   = in_valid_i && !in_stall_o;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // Milliseconds to ticks by a multiplication with the rounded-up reciprocal.
  assign ticks_prod = DIV_W'(cfg_data_i) * DIV_M;

  pwrseq_step u_step (
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .item_i   (in_item_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (step_fire) begin
        in_vld_q <= 1'b0;
      end
      if (step_fire) begin
        out_vld_q <= 1'b1;
        state_q   <= state_d;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= in_item_i;
    end
    if (step_fire) begin
      out_item_q <= result_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hot_restart       <= 1'b0;
      cfg_q.auto_restart      <= 1'b0;
      cfg_q.latching_switch   <= 1'b0;
      cfg_q.boot_finish_ms    <= BOOT_FINISH_RST;
      cfg_q.boot_pause        <= BOOT_PAUSE_RST;
      cfg_q.unmute_timeout_ms <= UNMUTE_TMO_RST;
    end else if (cfg_we) begin
      case (cfg_index_i)
        REG_HOT_RESTART:  cfg_q.hot_restart     <= cfg_data_i[0];
        REG_AUTO_RESTART: cfg_q.auto_restart    <= cfg_data_i[0];
        REG_LATCHING_SW:  cfg_q.latching_switch <= cfg_data_i[0];
        REG_BOOT_FINISH: begin
          cfg_q.boot_finish_ms <= cfg_data_i;
          cfg_q.boot_pause     <= ticks_prod[DIV_SH +: 16];
        end
        REG_UNMUTE_TMO:   cfg_q.unmute_timeout_ms <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_item_q;

  // The input side only stalls while an item is waiting in the input register.
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_vld_q)
    else $error("input stalled with an empty input register");

  // A running result always reports the running state.
  a_running_reported: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_item_q.running_flag) |-> (out_item_q.run_state == REP_RUNNING))
    else $error("running flag without running state");

  // A tick during a pause never moves the phase.
  a_pause_holds_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_fire && in_item_q.operation != OP_START && state_q.pause_count != 16'd0)
    |=> (state_q.phase == $past(state_q.phase)))
    else $error("phase changed during a pause");

  // The active-state change code never takes its unused value.
  a_active_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_item_q.active_change != 2'd3))
    else $error("invalid active-state change code");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for power_up_down_sequencer_top: directed and random start and tick
// items, with an item-level predictor of the phase sequencer. Depends on pwrseq_pkg and the RTL.
module tb_top;
  import pwrseq_pkg::*;

  // Operation code for a time-slice tick; the start code comes from the package.
  localparam logic OP_TICK = ~OP_START;

  // Pause lengths of the sequencer in milliseconds.
  localparam int MUTE_MS    = 200;
  localparam int POWER_MS   = 1000;
  localparam int SHUT_MS    = 100;
  localparam int RESTART_MS = 1000;

  localparam int LONG_HOLD   = 64;    // cycles for which the status sink refuses results
  localparam int QUIET_LIMIT = 1000;  // cycles without any handshake before giving up

  // Flag masks for the nine event bits that follow the operation bit of an item.
  localparam logic [8:0] F_PG    = 9'b1_0000_0000;
  localparam logic [8:0] F_ON    = 9'b0_1000_0000;
  localparam logic [8:0] F_OFF   = 9'b0_0100_0000;
  localparam logic [8:0] F_REL   = 9'b0_0010_0000;
  localparam logic [8:0] F_LOCK  = 9'b0_0001_0000;
  localparam logic [8:0] F_PCOFF = 9'b0_0000_1000;
  localparam logic [8:0] F_BDOFF = 9'b0_0000_0100;
  localparam logic [8:0] F_PCCHG = 9'b0_0000_0010;
  localparam logic [8:0] F_BDCHG = 9'b0_0000_0001;
  localparam logic [8:0] F_ALL   = 9'h1FF;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   status_out;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data  = '0;

  power_up_down_sequencer_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (status_out),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Commands waiting to be offered, and the status reports predicted for accepted commands.
  in_item_t  sequencer_cmds[$];
  out_item_t status_reports[$];

  int   mismatches   = 0;
  int   quiet_cycles = 0;
  logic in_took  = 1'b0;
  logic out_took = 1'b0;
  logic gaps_on  = 1'b1;
  int   send_gap = 0;
  int   sink_gap = 0;
  int   hold_left  = 0;
  int   hold_asks  = 0;
  int   holds_done = 0;

  // Predictor copy of the configuration registers, at their reset values.
  logic        cfg_hot    = 1'b0;
  logic        cfg_auto   = 1'b0;
  logic        cfg_latch  = 1'b0;
  logic [15:0] cfg_boot_ms   = BOOT_FINISH_RST;
  logic [15:0] cfg_unmute_ms = UNMUTE_TMO_RST;

  // Predictor copy of the sequencer state, as it stands after reset.
  logic [2:0]  seq_phase  = PH_NONE;
  logic [7:0]  steps      = '0;
  logic [15:0] pause      = '0;
  logic        rst_pend   = 1'b0;
  logic [2:0]  rep_state  = '0;

  // Outputs gathered while one item is stepped.
  logic [2:0]  p_led;
  logic [16:0] p_act;
  logic [15:0] p_mon;
  logic [1:0]  p_active;

  // The clock runs with a 20 ns period from time zero.
  initial begin : clock_gen
    forever #10 clk_i = ~clk_i;
  end

  function automatic in_item_t mk(logic op, logic [8:0] flags);
    return in_item_t'({op, flags});
  endfunction

  function automatic int draw_gap();
    return gaps_on ? $urandom_range(0, 7) : 0;
  endfunction

  function automatic void store_reg(logic [2:0] idx, logic [15:0] data);
    case (idx)
      REG_HOT_RESTART:  cfg_hot       = data[0];
      REG_AUTO_RESTART: cfg_auto      = data[0];
      REG_LATCHING_SW:  cfg_latch     = data[0];
      REG_BOOT_FINISH:  cfg_boot_ms   = data;
      REG_UNMUTE_TMO:   cfg_unmute_ms = data;
      default: ;
    endcase
  endfunction

  // Entering a phase restarts its step count, drops any pause and may report a new run state.
  function automatic void enter_phase(logic [2:0] nxt);
    seq_phase = nxt;
    steps = '0;
    pause = '0;
    case (nxt)
      PH_STANDBY: begin
        rep_state = REP_STANDBY;
        p_act[A_SERDE] = 1'b1;
      end
      PH_BOOT, PH_HOT: begin
        rep_state = REP_BOOTING;
        p_act[A_SERIN] = 1'b1;
      end
      PH_RUN:  rep_state = REP_RUNNING;
      PH_SHUT: rep_state = REP_SHUTDOWN;
      default: ;
    endcase
    if (nxt == PH_BOOT || nxt == PH_RUN) p_active = ACT_SET;
    else if (nxt == PH_SHUT) p_active = ACT_CLEAR;
  endfunction

  // Works out the status report that one accepted item causes, and advances the state.
  function automatic out_item_t sequencer_step(in_item_t it);
    logic      cleared;
    out_item_t rep;
    p_led = LED_NONE;
    p_act = '0;
    p_mon = '0;
    p_active = ACT_NONE;
    cleared = 1'b0;
    if (it.operation == OP_START) begin
      rst_pend = cfg_auto;
      enter_phase(cfg_hot ? PH_HOT : PH_WAITPG);
    end else if (pause != 0) begin
      pause = pause - 16'd1;
    end else begin
      case (seq_phase)
        PH_WAITPG: begin
          if (steps == 0) begin
            steps = 8'd1;
            p_led = LED_VERY_FAST;
          end
          if (it.power_good) begin
            p_led = LED_SHOW_IDS;
            enter_phase(PH_STANDBY);
          end
        end
        PH_STANDBY: begin
          if (steps == 0) begin
            p_led = LED_STANDBY;
            steps = 8'd1;
          end else if (steps == 1) begin
            if (cfg_latch || it.switch_released) begin
              p_act[A_ARM] = 1'b1;
              steps = 8'd2;
            end
          end else if (steps == 2) begin
            if (it.switch_on_event || rst_pend) begin
              if (rst_pend) steps = 8'd3;
              else enter_phase(PH_BOOT);
              rst_pend = 1'b0;
            end
          end else begin
            // Automatic restart: count slices until a full second has gone by.
            steps = steps + 8'd1;
            if (steps >= 8'(RESTART_MS / RESTART_SLICE_MS)) enter_phase(PH_BOOT);
          end
        end
        PH_BOOT: begin
          case (steps)
            8'd0: begin
              steps = 8'd1;
              p_led = LED_MEDIUM;
              p_act[A_MUTE] = 1'b1;
              pause = 16'(MUTE_MS / TICK_MS);
            end
            8'd1: begin
              steps = 8'd2;
              p_act[A_PCINIT] = 1'b1;
              p_act[A_SYSON]  = 1'b1;
              p_act[A_BUS_EN] = 1'b1;
              pause = 16'(POWER_MS / TICK_MS);
            end
            8'd2: begin
              steps = 8'd3;
              p_act[A_PCON] = 1'b1;
              pause = 16'(POWER_MS / TICK_MS);
            end
            8'd3: begin
              steps = 8'd4;
              p_act[A_HOST_RST] = 1'b1;
              pause = cfg_boot_ms / 16'(TICK_MS);
            end
            8'd4: begin
              // The unmute window is counted from boot end, so it saturates at zero.
              p_act[A_MONSTART] = 1'b1;
              p_mon = (cfg_unmute_ms > cfg_boot_ms) ? cfg_unmute_ms - cfg_boot_ms : '0;
              enter_phase(PH_RUN);
              p_act[A_ARM] = 1'b1;
            end
            default: ;
          endcase
        end
        PH_RUN: begin
          if (it.switch_off_event && !it.system_locked) begin
            enter_phase(PH_SHUT);
          end else if (steps == 0) begin
            steps = 8'd1;
            p_led = LED_ON;
            p_act[A_HB] = 1'b1;
            cleared = 1'b1;
          end else if (steps == 1) begin
            steps = 8'd2;
          end
          if (!cleared) begin
            if (it.pc_changed)    p_act[A_GLITCH1] = 1'b1;
            if (it.board_changed) p_act[A_GLITCH2] = 1'b1;
          end
        end
        PH_SHUT: begin
          if (steps == 0) begin
            p_act[A_MONSTOP] = 1'b1;
            p_act[A_CLROVR]  = 1'b1;
            p_act[A_MUTE]    = 1'b1;
            p_act[A_ALLOFF]  = 1'b1;
            steps = 8'd1;
            p_led = LED_FAST;
            pause = 16'(SHUT_MS / TICK_MS);
          end else if (it.pc_is_off && it.board_is_off) begin
            p_act[A_SYSOFF] = 1'b1;
            enter_phase(PH_STANDBY);
            pause = 16'(POWER_MS / TICK_MS);
          end
        end
        PH_HOT: begin
          p_act[A_MONSTART] = 1'b1;
          p_mon = '0;
          enter_phase(PH_RUN);
          p_act[A_ARM] = 1'b1;
        end
        default: ;
      endcase
    end
    rep.run_state          = rep_state;
    rep.led_command        = p_led;
    rep.actions            = p_act;
    rep.monitor_timeout_ms = p_mon;
    rep.running_flag       = (seq_phase == PH_RUN);
    rep.active_change      = p_active;
    return rep;
  endfunction

  function automatic void check_field(string name, logic [16:0] want, logic [16:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // Sample both item handshakes and the register port at the rising edge. Results are checked
  // against the oldest prediction; each accepted command is stepped through the predictor.
  always @(posedge clk_i) begin : status_check
    out_item_t want;
    if (!rst_ni) begin
      in_took  <= 1'b0;
      out_took <= 1'b0;
    end else begin
      in_took  <= in_valid && !in_stall;
      out_took <= out_valid && !out_stall;
      if (cfg_valid && cfg_ready) store_reg(cfg_index, cfg_data);
      if (out_valid && !out_stall) begin
        if (status_reports.size() == 0) begin
          mismatches++;
          $display("%0t: status item with no prediction waiting, expected none, actual %0h",
                   $time, status_out);
        end else begin
          want = status_reports.pop_front();
          check_field("run_state", 17'(want.run_state), 17'(status_out.run_state));
          check_field("led_command", 17'(want.led_command), 17'(status_out.led_command));
          check_field("actions", want.actions, status_out.actions);
          check_field("monitor_timeout_ms", 17'(want.monitor_timeout_ms),
                      17'(status_out.monitor_timeout_ms));
          check_field("running_flag", 17'(want.running_flag), 17'(status_out.running_flag));
          check_field("active_change", 17'(want.active_change),
                      17'(status_out.active_change));
        end
      end
      if (in_valid && !in_stall) status_reports.push_back(sequencer_step(in_item));
    end
  end

  // The command driver works at the falling edge. A command stays on the port until it has
  // been taken; then the drawn gap passes before the next one is offered.
  always @(negedge clk_i) begin : command_driver
    logic     offer;
    in_item_t cmd;
    offer = in_valid;
    cmd   = in_item;
    if (offer && in_took) offer = 1'b0;
    if (!offer && rst_ni) begin
      if (send_gap != 0) begin
        send_gap--;
      end else if (sequencer_cmds.size() != 0) begin
        cmd      = sequencer_cmds.pop_front();
        offer    = 1'b1;
        send_gap = draw_gap();
      end
    end
    in_valid <= offer;
    in_item  <= cmd;
  end

  // The status sink stalls for a drawn number of cycles after each result it takes, and
  // for one long stretch whenever the stimulus asks for it, so that the block backs up.
  always @(negedge clk_i) begin : status_sink
    logic hold;
    if (out_took) sink_gap = draw_gap();
    if (hold_left == 0 && holds_done != hold_asks) begin
      hold_left = LONG_HOLD;
      holds_done++;
    end
    if (hold_left != 0) begin
      hold_left--;
      hold = 1'b1;
    end else if (sink_gap != 0) begin
      sink_gap--;
      hold = 1'b1;
    end else begin
      hold = 1'b0;
    end
    out_stall <= hold;
  end

  // The run is abandoned when no handshake of any kind has happened for too long.
  always @(posedge clk_i) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAIL power_up_down_sequencer_top");
      $finish;
    end
  end

  // Waits until every queued command has been taken and every status item has arrived,
  // then lets the two-stage pipeline drain.
  task automatic wait_idle();
    do @(posedge clk_i);
    while (sequencer_cmds.size() != 0 || in_valid || status_reports.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Register writes are issued back to back; the port is released by end_writes.
  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i);
    while (!cfg_ready);
  endtask

  task automatic end_writes();
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_setting(logic hot, logic auto_rs, logic latch, logic [15:0] boot_ms,
                               logic [15:0] unmute_ms);
    write_reg(REG_HOT_RESTART, {15'($urandom), hot});
    write_reg(REG_AUTO_RESTART, {15'($urandom), auto_rs});
    write_reg(REG_LATCHING_SW, {15'($urandom), latch});
    write_reg(REG_BOOT_FINISH, boot_ms);
    write_reg(REG_UNMUTE_TMO, unmute_ms);
    end_writes();
  endtask

  // One well-formed run: a start, then ticks whose flags are random. With each flag high half
  // the time the sequencer walks through every phase on its own; off events are made rarer
  // so that it stays in running for a while, and stray starts act as noise.
  task automatic queue_run(int ticks, int start_permille, int off_pct);
    in_item_t it;
    sequencer_cmds.push_back(mk(OP_START, 9'($urandom)));
    repeat (ticks) begin
      it = mk(OP_TICK, 9'($urandom));
      if ($urandom_range(0, 999) < start_permille) it.operation = OP_START;
      it.switch_off_event = ($urandom_range(0, 99) < off_pct);
      sequencer_cmds.push_back(it);
    end
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Cold start with the reset configuration: ticks before any start do nothing, then the
    // sequencer waits for power good, arms the switch on release and boots on an on event.
    sequencer_cmds.push_back(mk(OP_TICK, F_ALL));
    sequencer_cmds.push_back(mk(OP_TICK, '0));
    sequencer_cmds.push_back(mk(OP_START, F_ALL));
    sequencer_cmds.push_back(mk(OP_TICK, '0));
    sequencer_cmds.push_back(mk(OP_TICK, F_ON | F_REL));
    sequencer_cmds.push_back(mk(OP_TICK, F_PG));
    sequencer_cmds.push_back(mk(OP_TICK, F_REL));
    sequencer_cmds.push_back(mk(OP_TICK, F_ON));
    sequencer_cmds.push_back(mk(OP_TICK, F_REL));
    sequencer_cmds.push_back(mk(OP_TICK, F_REL));
    sequencer_cmds.push_back(mk(OP_TICK, F_ON));
    sequencer_cmds.push_back(mk(OP_TICK, F_ALL));
    sequencer_cmds.push_back(mk(OP_TICK, F_ALL));
    wait_idle();

    // Hot restart straight into running. The first running step clears the change flags, a
    // locked system ignores the off event, and an unlocked off event still reports glitches.
    write_reg(REG_HOT_RESTART, 16'd1);
    end_writes();
    sequencer_cmds.push_back(mk(OP_START, '0));
    sequencer_cmds.push_back(mk(OP_TICK, F_PCCHG | F_BDCHG));
    sequencer_cmds.push_back(mk(OP_TICK, F_PCCHG | F_BDCHG));
    sequencer_cmds.push_back(mk(OP_TICK, F_PCCHG));
    sequencer_cmds.push_back(mk(OP_TICK, F_OFF | F_LOCK | F_BDCHG));
    sequencer_cmds.push_back(mk(OP_TICK, F_OFF | F_PCCHG | F_BDCHG));
    sequencer_cmds.push_back(mk(OP_TICK, '0));
    repeat (SHUT_MS / TICK_MS) sequencer_cmds.push_back(mk(OP_TICK, F_ALL));
    sequencer_cmds.push_back(mk(OP_TICK, F_PCOFF));
    sequencer_cmds.push_back(mk(OP_TICK, F_PCOFF | F_BDOFF));
    wait_idle();

    // Shortest boot with the widest unmute window; indexes beyond the list are ignored.
    apply_setting(1'b0, 1'b0, 1'b0, 16'd0, 16'hFFFF);
    for (int r = REG_UNMUTE_TMO + 1; r < 8; r++) write_reg(3'(r), 16'($urandom));
    end_writes();
    queue_run(350, 3, 8);
    hold_asks++;
    wait_idle();

    // Automatic restart with a latching switch and an unmute window shorter than the boot.
    apply_setting(1'b0, 1'b1, 1'b1, 16'd1234, 16'd999);
    queue_run(450, 3, 15);
    wait_idle();

    // Frequent hot restarts, no gaps on either side but for one long stall of the status sink.
    gaps_on = 1'b0;
    apply_setting(1'b1, 1'b1, 1'b0, 16'd37, 16'd40);
    queue_run(300, 20, 20);
    hold_asks++;
    wait_idle();
    gaps_on = 1'b1;

    // Longest boot finish setting, whose pause is loaded but not counted out, with no unmute
    // window at all.
    apply_setting(1'b0, 1'b0, 1'b1, 16'hFFFF, 16'd0);
    queue_run(250, 0, 10);
    wait_idle();

    // Back to the reset timing with hot restart and a latching switch.
    apply_setting(1'b1, 1'b0, 1'b1, BOOT_FINISH_RST, UNMUTE_TMO_RST);
    queue_run(200, 5, 10);
    wait_idle();

    if (mismatches == 0 && status_reports.size() == 0) begin
      $display("PASS power_up_down_sequencer_top");
    end else begin
      $display("FAIL power_up_down_sequencer_top");
    end
    $finish;
  end

endmodule
